FILE: rtl/core/mhpq_pkg.sv
package mhpq_pkg;

    // Sizes of the heap and of one stored word
    localparam int CAPACITY  = 1024;
    localparam int ID_BITS   = 16;
    localparam int KEY_BITS  = 32;
    localparam int ADDR_BITS = $clog2(CAPACITY);
    localparam int CNT_BITS  = $clog2(CAPACITY + 1);
    localparam int WIDE_BITS = ADDR_BITS + 2;

    // Command codes
    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_POP    = 1'b1;

    typedef logic [ADDR_BITS-1:0] t_addr;
    typedef logic [CNT_BITS-1:0]  t_count;
    typedef logic [WIDE_BITS-1:0] t_wide;

    typedef struct packed {
        logic [ID_BITS-1:0]  id;
        logic [KEY_BITS-1:0] key;
    } t_entry;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_UP_CHK,
        ST_UP_CMP,
        ST_POP_ROOT,
        ST_POP_LAST,
        ST_DN_CHK,
        ST_DN_C1,
        ST_DN_C2
    } t_state;

    // Read address source
    typedef enum logic [2:0] {
        RD_ROOT,
        RD_LAST,
        RD_PARENT,
        RD_C1,
        RD_C2
    } t_rd_src;

    // Write data source (address is always the current hole)
    typedef enum logic [1:0] {
        WR_MOV,
        WR_RDATA,
        WR_C1
    } t_wr_src;

    // Next hole position
    typedef enum logic [2:0] {
        POS_HOLD,
        POS_ZERO,
        POS_PARENT,
        POS_C1,
        POS_C2
    } t_pos_src;

    // Kind of result word
    typedef enum logic [1:0] {
        RES_INSERT,
        RES_POP,
        RES_EMPTY,
        RES_FULL
    } t_res;

    typedef struct packed {
        logic     accept_ins;
        logic     accept_pop;
        logic     rd_en;
        t_rd_src  rd_src;
        logic     wr_en;
        t_wr_src  wr_src;
        t_pos_src pos_src;
        logic     ld_mov;
        logic     ld_c1;
        logic     ld_popped;
        logic     res_en;
        t_res     res_kind;
    } t_dp_cmd;

    typedef struct packed {
        logic full;
        logic empty;
        logic pos_zero;
        logic has_c1;
        logic has_c2;
        logic up_swap;
        logic dn_c1;
        logic sel1;
        logic sel2;
    } t_dp_stat;

endpackage

FILE: rtl/core/mhpq_ram.sv
module mhpq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port, holds when not enabled
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: rtl/core/mhpq_ctrl.sv
module mhpq_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic              i_command,
    input  mhpq_pkg::t_dp_stat i_stat,
    output mhpq_pkg::t_dp_cmd  o_cmd,
    output logic              o_busy
);

    mhpq_pkg::t_state r_state;
    mhpq_pkg::t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mhpq_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and datapath commands
    always_comb begin
        n_state        = r_state;
        o_cmd          = '0;
        o_cmd.rd_src   = mhpq_pkg::RD_ROOT;
        o_cmd.wr_src   = mhpq_pkg::WR_MOV;
        o_cmd.pos_src  = mhpq_pkg::POS_HOLD;
        o_cmd.res_kind = mhpq_pkg::RES_INSERT;
        unique case (r_state)
            mhpq_pkg::ST_IDLE: begin
                if (i_start) begin
                    if (i_command == mhpq_pkg::CMD_INSERT) begin
                        if (i_stat.full) begin
                            o_cmd.res_en   = 1'b1;
                            o_cmd.res_kind = mhpq_pkg::RES_FULL;
                        end else begin
                            o_cmd.accept_ins = 1'b1;
                            n_state          = mhpq_pkg::ST_UP_CHK;
                        end
                    end else begin
                        if (i_stat.empty) begin
                            o_cmd.res_en   = 1'b1;
                            o_cmd.res_kind = mhpq_pkg::RES_EMPTY;
                        end else begin
                            o_cmd.accept_pop = 1'b1;
                            o_cmd.rd_en      = 1'b1;
                            o_cmd.rd_src     = mhpq_pkg::RD_ROOT;
                            n_state          = mhpq_pkg::ST_POP_ROOT;
                        end
                    end
                end
            end
            // Sift up: at the root write the new word and finish, else fetch the parent of the hole
            mhpq_pkg::ST_UP_CHK: begin
                if (i_stat.pos_zero) begin
                    o_cmd.wr_en    = 1'b1;
                    o_cmd.wr_src   = mhpq_pkg::WR_MOV;
                    o_cmd.res_en   = 1'b1;
                    o_cmd.res_kind = mhpq_pkg::RES_INSERT;
                    n_state        = mhpq_pkg::ST_IDLE;
                end else begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_src = mhpq_pkg::RD_PARENT;
                    n_state      = mhpq_pkg::ST_UP_CMP;
                end
            end
            // Move the parent down or drop the new word into the hole
            mhpq_pkg::ST_UP_CMP: begin
                o_cmd.wr_en = 1'b1;
                if (i_stat.up_swap) begin
                    o_cmd.wr_src  = mhpq_pkg::WR_RDATA;
                    o_cmd.pos_src = mhpq_pkg::POS_PARENT;
                    n_state       = mhpq_pkg::ST_UP_CHK;
                end else begin
                    o_cmd.wr_src   = mhpq_pkg::WR_MOV;
                    o_cmd.res_en   = 1'b1;
                    o_cmd.res_kind = mhpq_pkg::RES_INSERT;
                    n_state        = mhpq_pkg::ST_IDLE;
                end
            end
            // Capture the root; fetch the last word, or finish if the heap is now empty
            mhpq_pkg::ST_POP_ROOT: begin
                o_cmd.ld_popped = 1'b1;
                if (i_stat.empty) begin
                    o_cmd.res_en   = 1'b1;
                    o_cmd.res_kind = mhpq_pkg::RES_POP;
                    n_state        = mhpq_pkg::ST_IDLE;
                end else begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_src = mhpq_pkg::RD_LAST;
                    n_state      = mhpq_pkg::ST_POP_LAST;
                end
            end
            mhpq_pkg::ST_POP_LAST: begin
                o_cmd.ld_mov  = 1'b1;
                o_cmd.pos_src = mhpq_pkg::POS_ZERO;
                n_state       = mhpq_pkg::ST_DN_CHK;
            end
            // Sift down: fetch the first child, or with none write the moved word and finish
            mhpq_pkg::ST_DN_CHK: begin
                if (i_stat.has_c1) begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_src = mhpq_pkg::RD_C1;
                    n_state      = mhpq_pkg::ST_DN_C1;
                end else begin
                    o_cmd.wr_en    = 1'b1;
                    o_cmd.wr_src   = mhpq_pkg::WR_MOV;
                    o_cmd.res_en   = 1'b1;
                    o_cmd.res_kind = mhpq_pkg::RES_POP;
                    n_state        = mhpq_pkg::ST_IDLE;
                end
            end
            // Hold the first child; fetch the second or decide on one child
            mhpq_pkg::ST_DN_C1: begin
                o_cmd.ld_c1 = 1'b1;
                if (i_stat.has_c2) begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_src = mhpq_pkg::RD_C2;
                    n_state      = mhpq_pkg::ST_DN_C2;
                end else if (i_stat.dn_c1) begin
                    o_cmd.wr_en   = 1'b1;
                    o_cmd.wr_src  = mhpq_pkg::WR_RDATA;
                    o_cmd.pos_src = mhpq_pkg::POS_C1;
                    n_state       = mhpq_pkg::ST_DN_CHK;
                end else begin
                    o_cmd.wr_en    = 1'b1;
                    o_cmd.wr_src   = mhpq_pkg::WR_MOV;
                    o_cmd.res_en   = 1'b1;
                    o_cmd.res_kind = mhpq_pkg::RES_POP;
                    n_state        = mhpq_pkg::ST_IDLE;
                end
            end
            // Pick among hole, first and second child; ties go to the later one
            mhpq_pkg::ST_DN_C2: begin
                o_cmd.wr_en = 1'b1;
                priority if (i_stat.sel2) begin
                    o_cmd.wr_src  = mhpq_pkg::WR_RDATA;
                    o_cmd.pos_src = mhpq_pkg::POS_C2;
                    n_state       = mhpq_pkg::ST_DN_CHK;
                end else if (i_stat.sel1) begin
                    o_cmd.wr_src  = mhpq_pkg::WR_C1;
                    o_cmd.pos_src = mhpq_pkg::POS_C1;
                    n_state       = mhpq_pkg::ST_DN_CHK;
                end else begin
                    o_cmd.wr_src   = mhpq_pkg::WR_MOV;
                    o_cmd.res_en   = 1'b1;
                    o_cmd.res_kind = mhpq_pkg::RES_POP;
                    n_state        = mhpq_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = mhpq_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != mhpq_pkg::ST_IDLE);

`ifndef SYNTHESIS
    // A finished word leaves the controller idle
    a_res_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.res_en |=> (r_state == mhpq_pkg::ST_IDLE))
        else $error("result issued but controller not idle");

    // Never read and write in the same cycle
    a_no_rw_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_cmd.rd_en && o_cmd.wr_en))
        else $error("read and write issued together");

    // A word is accepted only from idle
    a_accept_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.accept_ins || o_cmd.accept_pop) |-> !o_busy)
        else $error("word accepted while busy");
`endif

endmodule

FILE: rtl/core/mhpq_dp.sv
module mhpq_dp (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic [mhpq_pkg::ID_BITS-1:0]    i_node_id,
    input  logic [mhpq_pkg::KEY_BITS-1:0]   i_dist_key,
    input  mhpq_pkg::t_dp_cmd               i_cmd,
    output mhpq_pkg::t_dp_stat              o_stat,
    output logic [mhpq_pkg::ID_BITS-1:0]    o_popped_id,
    output logic [mhpq_pkg::KEY_BITS-1:0]   o_popped_key,
    output logic                            o_was_empty,
    output logic                            o_was_full,
    output logic [mhpq_pkg::CNT_BITS-1:0]   o_fill_level,
    output logic                            o_done
);

    mhpq_pkg::t_count r_count, n_count;
    mhpq_pkg::t_addr  r_pos, n_pos;
    mhpq_pkg::t_entry r_mov, n_mov;
    mhpq_pkg::t_entry r_c1, n_c1;
    mhpq_pkg::t_entry r_pop, n_pop;
    mhpq_pkg::t_entry r_out, n_out;
    logic             r_empty, n_empty;
    logic             r_full, n_full;
    mhpq_pkg::t_count r_fill, n_fill;
    logic             r_done, n_done;

    mhpq_pkg::t_entry w_rdata;
    mhpq_pkg::t_entry w_wdata;
    mhpq_pkg::t_addr  w_rd_addr;
    mhpq_pkg::t_addr  w_parent;
    mhpq_pkg::t_wide  w_c1;
    mhpq_pkg::t_wide  w_c2;
    mhpq_pkg::t_wide  w_cnt;
    logic [mhpq_pkg::KEY_BITS-1:0] w_ukey;

    // Heap storage, one word holds id and key
    mhpq_ram #(
        .WIDTH ($bits(mhpq_pkg::t_entry)),
        .DEPTH (mhpq_pkg::CAPACITY)
    ) u_heap (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.wr_en),
        .i_wr_addr (r_pos),
        .i_wr_data (w_wdata),
        .i_rd_en   (i_cmd.rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rdata)
    );

    // Tree addressing around the hole
    assign w_parent = mhpq_pkg::ADDR_BITS'(r_pos - mhpq_pkg::ADDR_BITS'(1)) >> 1;
    assign w_c1     = {1'b0, r_pos, 1'b0} + mhpq_pkg::WIDE_BITS'(1);
    assign w_c2     = {1'b0, r_pos, 1'b0} + mhpq_pkg::WIDE_BITS'(2);
    assign w_cnt    = mhpq_pkg::WIDE_BITS'(r_count);

    always_comb begin
        unique case (i_cmd.rd_src)
            mhpq_pkg::RD_ROOT:   w_rd_addr = '0;
            mhpq_pkg::RD_LAST:   w_rd_addr = mhpq_pkg::ADDR_BITS'(r_count);
            mhpq_pkg::RD_PARENT: w_rd_addr = w_parent;
            mhpq_pkg::RD_C1:     w_rd_addr = w_c1[mhpq_pkg::ADDR_BITS-1:0];
            mhpq_pkg::RD_C2:     w_rd_addr = w_c2[mhpq_pkg::ADDR_BITS-1:0];
            default:             w_rd_addr = '0;
        endcase
    end

    always_comb begin
        unique case (i_cmd.wr_src)
            mhpq_pkg::WR_MOV:   w_wdata = r_mov;
            mhpq_pkg::WR_RDATA: w_wdata = w_rdata;
            mhpq_pkg::WR_C1:    w_wdata = r_c1;
            default:            w_wdata = r_mov;
        endcase
    end

    // Status for the controller
    assign w_ukey = o_stat.sel1 ? r_c1.key : r_mov.key;
    always_comb begin
        o_stat.full     = (r_count == mhpq_pkg::CNT_BITS'(mhpq_pkg::CAPACITY));
        o_stat.empty    = (r_count == '0);
        o_stat.pos_zero = (r_pos == '0);
        o_stat.has_c1   = (w_c1 < w_cnt);
        o_stat.has_c2   = (w_c2 < w_cnt);
        o_stat.up_swap  = (w_rdata.key >= r_mov.key);
        o_stat.dn_c1    = (r_mov.key >= w_rdata.key);
        o_stat.sel1     = (r_mov.key >= r_c1.key);
        o_stat.sel2     = (w_ukey >= w_rdata.key);
    end

    // Next values of the working registers
    always_comb begin
        n_count = r_count;
        n_pos   = r_pos;
        n_mov   = r_mov;
        n_c1    = r_c1;
        n_pop   = r_pop;
        if (i_cmd.accept_ins) begin
            n_mov.id  = i_node_id;
            n_mov.key = i_dist_key;
            n_pos     = mhpq_pkg::ADDR_BITS'(r_count);
            n_count   = r_count + mhpq_pkg::CNT_BITS'(1);
        end
        if (i_cmd.accept_pop) begin
            n_count = r_count - mhpq_pkg::CNT_BITS'(1);
        end
        if (i_cmd.ld_mov) begin
            n_mov = w_rdata;
        end
        if (i_cmd.ld_c1) begin
            n_c1 = w_rdata;
        end
        if (i_cmd.ld_popped) begin
            n_pop = w_rdata;
        end
        unique case (i_cmd.pos_src)
            mhpq_pkg::POS_HOLD:   ;
            mhpq_pkg::POS_ZERO:   n_pos = '0;
            mhpq_pkg::POS_PARENT: n_pos = w_parent;
            mhpq_pkg::POS_C1:     n_pos = w_c1[mhpq_pkg::ADDR_BITS-1:0];
            mhpq_pkg::POS_C2:     n_pos = w_c2[mhpq_pkg::ADDR_BITS-1:0];
            default:              ;
        endcase
    end

    // Result word
    always_comb begin
        n_out   = r_out;
        n_empty = r_empty;
        n_full  = r_full;
        n_fill  = r_fill;
        n_done  = i_cmd.res_en;
        if (i_cmd.res_en) begin
            n_out   = '0;
            n_empty = 1'b0;
            n_full  = 1'b0;
            n_fill  = r_count;
            unique case (i_cmd.res_kind)
                mhpq_pkg::RES_INSERT: ;
                mhpq_pkg::RES_POP:    n_out = i_cmd.ld_popped ? w_rdata : r_pop;
                mhpq_pkg::RES_EMPTY:  n_empty = 1'b1;
                mhpq_pkg::RES_FULL:   n_full = 1'b1;
                default:              ;
            endcase
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_count <= n_count;
            r_done  <= n_done;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_pos   <= n_pos;
        r_mov   <= n_mov;
        r_c1    <= n_c1;
        r_pop   <= n_pop;
        r_out   <= n_out;
        r_empty <= n_empty;
        r_full  <= n_full;
        r_fill  <= n_fill;
    end

    assign o_popped_id  = r_out.id;
    assign o_popped_key = r_out.key;
    assign o_was_empty  = r_empty;
    assign o_was_full   = r_full;
    assign o_fill_level = r_fill;
    assign o_done       = r_done;

`ifndef SYNTHESIS
    // Every write lands inside the live part of the heap
    a_wr_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.wr_en |-> (mhpq_pkg::WIDE_BITS'(r_pos) < w_cnt))
        else $error("heap write beyond fill count");

    // An accepted insert grows the heap by exactly one
    a_ins_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.accept_ins |=> (r_count == $past(r_count) + mhpq_pkg::CNT_BITS'(1)))
        else $error("insert did not advance fill count");

    // A result never flags both empty and full
    a_flags_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !(r_empty && r_full))
        else $error("empty and full flagged together");
`endif

endmodule

FILE: rtl/core/min_heap_priority_queue_core.sv
// Channel   Ports                                          Handshake
// command   i_command, i_node_id, i_dist_key               taken when i_start && !o_busy
// result    o_popped_id, o_popped_key, o_was_empty,        one cycle, marked by o_done
//           o_was_full, o_fill_level
//
// Insert: climbs one level per ST_UP_CHK/ST_UP_CMP pass and writes the new word where it stops.
// Pop: reads root and last word, then sinks one level per pass through the ST_DN_* states;
// the last entry's pop ends at the root read. Each level reads each child through one RAM port.
// Pop on empty or insert when full: result in the next cycle, no busy time.
// Synchronous active-low reset empties the heap at once; RAM contents are left as they are.
// o_done pulses one cycle per word, right after the last busy cycle; the receiver cannot stall.
module min_heap_priority_queue_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    output logic                          o_busy,
    input  logic                          i_command,
    input  logic [mhpq_pkg::ID_BITS-1:0]  i_node_id,
    input  logic [mhpq_pkg::KEY_BITS-1:0] i_dist_key,
    output logic                          o_done,
    output logic [mhpq_pkg::ID_BITS-1:0]  o_popped_id,
    output logic [mhpq_pkg::KEY_BITS-1:0] o_popped_key,
    output logic                          o_was_empty,
    output logic                          o_was_full,
    output logic [mhpq_pkg::CNT_BITS-1:0] o_fill_level
);

    mhpq_pkg::t_dp_cmd  w_cmd;
    mhpq_pkg::t_dp_stat w_stat;

    // Sequencer
    mhpq_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (i_start),
        .i_command (i_command),
        .i_stat    (w_stat),
        .o_cmd     (w_cmd),
        .o_busy    (o_busy)
    );

    // Heap storage and result registers
    mhpq_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_node_id    (i_node_id),
        .i_dist_key   (i_dist_key),
        .i_cmd        (w_cmd),
        .o_stat       (w_stat),
        .o_popped_id  (o_popped_id),
        .o_popped_key (o_popped_key),
        .o_was_empty  (o_was_empty),
        .o_was_full   (o_was_full),
        .o_fill_level (o_fill_level),
        .o_done       (o_done)
    );

endmodule

FILE: tb/tb_min_heap_priority_queue_core.sv
`timescale 1ns / 100ps

module tb_min_heap_priority_queue_core;

    // One command word waiting for the driver; a drain word holds the driver
    // until every owed result has come back
    typedef struct packed {
        logic                          drain;
        logic                          cmd;
        logic [mhpq_pkg::ID_BITS-1:0]  id;
        logic [mhpq_pkg::KEY_BITS-1:0] key;
    } t_cmd_word;

    // One result word as the heap must report it
    typedef struct packed {
        logic [mhpq_pkg::ID_BITS-1:0]  id;
        logic [mhpq_pkg::KEY_BITS-1:0] key;
        logic                          empty;
        logic                          full;
        mhpq_pkg::t_count              fill;
    } t_heap_result;

    logic                          i_clk        = 1'b0;
    logic                          i_rst_n      = 1'b0;
    logic                          i_start      = 1'b0;
    logic                          i_command    = mhpq_pkg::CMD_INSERT;
    logic [mhpq_pkg::ID_BITS-1:0]  i_node_id    = '0;
    logic [mhpq_pkg::KEY_BITS-1:0] i_dist_key   = '0;
    logic                          o_busy;
    logic                          o_done;
    logic [mhpq_pkg::ID_BITS-1:0]  o_popped_id;
    logic [mhpq_pkg::KEY_BITS-1:0] o_popped_key;
    logic                          o_was_empty;
    logic                          o_was_full;
    mhpq_pkg::t_count              o_fill_level;

    t_cmd_word    cmd_backlog[$];
    t_heap_result owed_results[$];
    t_heap_result got_want;

    // Shadow heap kept by the predictor
    mhpq_pkg::t_entry heap_store [mhpq_pkg::CAPACITY];
    int unsigned      heap_fill = 0;

    // Fill level as tracked while the command list is built
    int unsigned plan_fill = 0;

    logic        took_word    = 1'b0;
    bit          mismatch_seen = 1'b0;
    int unsigned idle_left    = 0;
    int unsigned calm_left    = 0;
    int unsigned idle_roll;

    min_heap_priority_queue_core u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (i_start),
        .o_busy       (o_busy),
        .i_command    (i_command),
        .i_node_id    (i_node_id),
        .i_dist_key   (i_dist_key),
        .o_done       (o_done),
        .o_popped_id  (o_popped_id),
        .o_popped_key (o_popped_key),
        .o_was_empty  (o_was_empty),
        .o_was_full   (o_was_full),
        .o_fill_level (o_fill_level)
    );

    always #6 i_clk = ~i_clk;

    function automatic void swap_slots(input int unsigned a, input int unsigned b);
        mhpq_pkg::t_entry tmp;
        tmp = heap_store[a];
        heap_store[a] = heap_store[b];
        heap_store[b] = tmp;
    endfunction

    // Apply one command to the shadow heap and owe its result
    function automatic void apply_heap_cmd(input logic cmd,
                                           input logic [mhpq_pkg::ID_BITS-1:0] id,
                                           input logic [mhpq_pkg::KEY_BITS-1:0] key);
        t_heap_result res;
        int unsigned  pos;
        int unsigned  up;
        int unsigned  c1;
        int unsigned  c2;
        int unsigned  parent;
        res = '0;
        if (cmd == mhpq_pkg::CMD_INSERT) begin
            if (heap_fill >= mhpq_pkg::CAPACITY) begin
                res.full = 1'b1;
            end else begin
                heap_store[heap_fill].id  = id;
                heap_store[heap_fill].key = key;
                pos = heap_fill;
                heap_fill++;
                // climb past parents whose key is greater or equal
                while (pos != 0) begin
                    parent = (pos - 1) / 2;
                    if (heap_store[parent].key >= heap_store[pos].key) begin
                        swap_slots(parent, pos);
                        pos = parent;
                    end else begin
                        break;
                    end
                end
            end
        end else begin
            if (heap_fill == 0) begin
                res.empty = 1'b1;
            end else begin
                res.id  = heap_store[0].id;
                res.key = heap_store[0].key;
                heap_store[0] = heap_store[heap_fill - 1];
                heap_fill--;
                // sink toward the smaller child; ties go down, second child wins
                pos = 0;
                forever begin
                    up = pos;
                    c1 = 2 * pos + 1;
                    c2 = 2 * pos + 2;
                    if (c2 < heap_fill) begin
                        if (heap_store[pos].key >= heap_store[c1].key) up = c1;
                        if (heap_store[up].key >= heap_store[c2].key) up = c2;
                    end else if (c1 < heap_fill) begin
                        if (heap_store[pos].key >= heap_store[c1].key) up = c1;
                    end
                    if (up == pos) break;
                    swap_slots(pos, up);
                    pos = up;
                end
            end
        end
        res.fill = mhpq_pkg::t_count'(heap_fill);
        owed_results = {owed_results, res};
    endfunction

    // Keys lean toward extremes and a narrow range so that ties are common
    function automatic logic [mhpq_pkg::KEY_BITS-1:0] draw_key();
        int unsigned pick;
        pick = $urandom_range(0, 9);
        case (pick)
            0: return '0;
            1: return '1;
            2, 3, 4: return mhpq_pkg::KEY_BITS'($urandom_range(0, 7));
            default: return mhpq_pkg::KEY_BITS'($urandom);
        endcase
    endfunction

    task automatic queue_word(input logic cmd, input logic [mhpq_pkg::ID_BITS-1:0] id,
                              input logic [mhpq_pkg::KEY_BITS-1:0] key);
        t_cmd_word w;
        w.drain = 1'b0;
        w.cmd   = cmd;
        w.id    = id;
        w.key   = key;
        cmd_backlog = {cmd_backlog, w};
        if (cmd == mhpq_pkg::CMD_INSERT && plan_fill < mhpq_pkg::CAPACITY) plan_fill++;
        if (cmd == mhpq_pkg::CMD_POP && plan_fill > 0) plan_fill--;
    endtask

    task automatic queue_drain();
        t_cmd_word w;
        w.drain = 1'b1;
        w.cmd   = mhpq_pkg::CMD_INSERT;
        w.id    = '0;
        w.key   = '0;
        cmd_backlog = {cmd_backlog, w};
    endtask

    // Drive command words at the falling edge
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_start <= 1'b0;
        end else begin
            // retire the word taken at the last rising edge and draw the next gap
            if (took_word) begin
                void'(cmd_backlog.pop_front());
                if (calm_left != 0) begin
                    calm_left--;
                    idle_left = 0;
                end else begin
                    idle_roll = $urandom_range(0, 99);
                    if (idle_roll < 2) begin
                        calm_left = $urandom_range(20, 80);
                        idle_left = 0;
                    end else if (idle_roll < 50) begin
                        idle_left = 0;
                    end else if (idle_roll < 90) begin
                        idle_left = $urandom_range(1, 3);
                    end else begin
                        idle_left = $urandom_range(8, 40);
                    end
                end
            end
            if (i_start && !took_word) begin
                // hold the word until the block takes it
            end else if (idle_left != 0) begin
                idle_left--;
                i_start <= 1'b0;
            end else if (cmd_backlog.size() == 0) begin
                i_start <= 1'b0;
            end else if (cmd_backlog[0].drain) begin
                i_start <= 1'b0;
                if (owed_results.size() == 0) void'(cmd_backlog.pop_front());
            end else begin
                i_start    <= 1'b1;
                i_command  <= cmd_backlog[0].cmd;
                i_node_id  <= cmd_backlog[0].id;
                i_dist_key <= cmd_backlog[0].key;
            end
        end
    end

    // Check results and predict accepted words at the rising edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            took_word <= 1'b0;
        end else begin
            if (o_done) begin
                if (owed_results.size() == 0) begin
                    $display("%0t: result word with none owed: id %h key %h fill %0d",
                             $time, o_popped_id, o_popped_key, o_fill_level);
                    mismatch_seen = 1'b1;
                end else begin
                    got_want = owed_results.pop_front();
                    if (o_popped_id !== got_want.id) begin
                        $display("%0t: popped_id expected %h actual %h",
                                 $time, got_want.id, o_popped_id);
                        mismatch_seen = 1'b1;
                    end
                    if (o_popped_key !== got_want.key) begin
                        $display("%0t: popped_key expected %h actual %h",
                                 $time, got_want.key, o_popped_key);
                        mismatch_seen = 1'b1;
                    end
                    if (o_was_empty !== got_want.empty) begin
                        $display("%0t: was_empty expected %b actual %b",
                                 $time, got_want.empty, o_was_empty);
                        mismatch_seen = 1'b1;
                    end
                    if (o_was_full !== got_want.full) begin
                        $display("%0t: was_full expected %b actual %b",
                                 $time, got_want.full, o_was_full);
                        mismatch_seen = 1'b1;
                    end
                    if (o_fill_level !== got_want.fill) begin
                        $display("%0t: fill_level expected %0d actual %0d",
                                 $time, got_want.fill, o_fill_level);
                        mismatch_seen = 1'b1;
                    end
                end
            end
            if (i_start && !o_busy) apply_heap_cmd(i_command, i_node_id, i_dist_key);
            took_word <= i_start && !o_busy;
        end
    end

    // Build the command list, release reset, wait for the last result
    initial begin
        int n;

        // pops on empty, extreme fields, equal keys, then empty it out again
        queue_word(mhpq_pkg::CMD_POP, '1, '1);
        queue_word(mhpq_pkg::CMD_POP, '0, '0);
        queue_word(mhpq_pkg::CMD_INSERT, '0, '1);
        queue_word(mhpq_pkg::CMD_INSERT, '1, '0);
        queue_word(mhpq_pkg::CMD_INSERT, 16'h1234, 32'd7);
        queue_word(mhpq_pkg::CMD_INSERT, 16'h1235, 32'd7);
        queue_word(mhpq_pkg::CMD_INSERT, 16'h1236, 32'd7);
        queue_word(mhpq_pkg::CMD_INSERT, 16'h8000, 32'h8000_0000);
        queue_word(mhpq_pkg::CMD_INSERT, 16'h7fff, 32'd7);
        queue_word(mhpq_pkg::CMD_INSERT, 16'h5a5a, 32'd0);
        for (n = 0; n < 8; n++) begin
            queue_word(mhpq_pkg::CMD_POP, mhpq_pkg::ID_BITS'($urandom),
                       mhpq_pkg::KEY_BITS'($urandom));
        end
        queue_word(mhpq_pkg::CMD_POP, '1, '1);
        queue_drain();

        // mixed traffic around a shallow heap
        for (n = 0; n < 300; n++) begin
            queue_word(($urandom_range(0, 99) < 55) ? mhpq_pkg::CMD_INSERT : mhpq_pkg::CMD_POP,
                       mhpq_pkg::ID_BITS'($urandom), draw_key());
        end
        queue_drain();

        // grow to capacity with a few pops along the way, then insert into the full heap and mix pops and inserts
        while (plan_fill < mhpq_pkg::CAPACITY) begin
            queue_word(($urandom_range(0, 99) < 92) ? mhpq_pkg::CMD_INSERT : mhpq_pkg::CMD_POP,
                       mhpq_pkg::ID_BITS'($urandom), draw_key());
        end
        queue_word(mhpq_pkg::CMD_INSERT, '1, '1);
        queue_word(mhpq_pkg::CMD_INSERT, '0, '0);
        for (n = 0; n < 4; n++) begin
            queue_word(mhpq_pkg::CMD_POP, mhpq_pkg::ID_BITS'($urandom),
                       mhpq_pkg::KEY_BITS'($urandom));
            queue_word(mhpq_pkg::CMD_INSERT, mhpq_pkg::ID_BITS'($urandom), draw_key());
        end
        queue_word(mhpq_pkg::CMD_INSERT, mhpq_pkg::ID_BITS'($urandom), draw_key());
        queue_drain();

        // mostly pops out of a deep heap
        for (n = 0; n < 200; n++) begin
            queue_word(($urandom_range(0, 99) < 20) ? mhpq_pkg::CMD_INSERT : mhpq_pkg::CMD_POP,
                       mhpq_pkg::ID_BITS'($urandom), draw_key());
        end

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (cmd_backlog.size() != 0 || i_start || owed_results.size() != 0)
            @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (mismatch_seen) begin
            $display("Simulation FAILED");
        end else begin
            $display("Simulation PASSED");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #40_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
